/* rtl/core/crc_checked_frame_parser_macros.svh */
// Assertion macros for the frame parser RTL.
// Depends on nothing; included by cfp_parser, the module that carries concurrent assertions.
`ifndef CRC_CHECKED_FRAME_PARSER_MACROS_SVH
`define CRC_CHECKED_FRAME_PARSER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CFP_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("frame parser check failed");

// Next-cycle implication, checked outside reset.
`define CFP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("frame parser check failed");

`endif

/* rtl/core/cfp_pkg.sv */
// Shared types, codes and the CRC16/XMODEM byte update for the frame parser.
// Depends on nothing; imported by every module in rtl/core.
package cfp_pkg;

  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CfgHeadByte  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxVer    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgMaxPayld  = 2'd2;

  localparam logic [7:0]  HeadByteRst   = 8'd90;
  localparam logic [7:0]  MaxVerRst     = 8'd1;
  localparam logic [15:0] MaxPayloadRst = 16'd256;

  // Header length counted from the head byte: head, 4 header bytes, 2 length bytes,
  // plus one when an address byte is present.
  localparam logic [3:0] HdrLenNoAddr = 4'd7;
  localparam logic [3:0] HdrLenAddr   = 4'd8;

  localparam logic [15:0] CrcPoly = 16'h1021;

  localparam logic [2:0] ST_HUNT     = 3'd0;
  localparam logic [2:0] ST_RECV     = 3'd1;
  localparam logic [2:0] ST_DONE     = 3'd2;
  localparam logic [2:0] ST_VER_ERR  = 3'd3;
  localparam logic [2:0] ST_SIZE_ERR = 3'd4;
  localparam logic [2:0] ST_CRC_ERR  = 3'd5;
  localparam logic [2:0] ST_DROPPED  = 3'd6;

  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        is_payload;
    logic [7:0]  out_byte;
    logic [7:0]  frame_type;
    logic [7:0]  frame_version;
    logic [3:0]  frame_class;
    logic        data_bit;
    logic        has_addr;
    logic [7:0]  msg_id;
    logic [7:0]  dev_addr;
    logic [15:0] payload_size;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  head_byte;
    logic [7:0]  max_version;
    logic [15:0] max_payload;
  } cfg_t;

  // One byte through CRC16/XMODEM, MSB first.
  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CrcPoly) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

/* rtl/core/cfp_cfg_regs.sv */
// Configuration register file of the frame parser.
// Depends on cfp_pkg for the register indexes, reset values and cfg_t.
module cfp_cfg_regs import cfp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgHeadByte: cfg_d.head_byte   = cfg_data_i[7:0];
        CfgMaxVer:   cfg_d.max_version = cfg_data_i[7:0];
        CfgMaxPayld: cfg_d.max_payload = cfg_data_i;
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.head_byte   <= HeadByteRst;
      cfg_q.max_version <= MaxVerRst;
      cfg_q.max_payload <= MaxPayloadRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

/* rtl/core/cfp_parser.sv */
// Frame parser state and per-byte step logic: phase, counters, CRC, captured header.
// Depends on cfp_pkg and the assertion macros header.
`include "crc_checked_frame_parser_macros.svh"

module cfp_parser import cfp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_item_t  item_i,
  input  cfg_t      cfg_i,
  output out_item_t res_o
);

  localparam logic [3:0] PH_HUNT    = 4'd0;
  localparam logic [3:0] PH_TYPE    = 4'd1;
  localparam logic [3:0] PH_VER     = 4'd2;
  localparam logic [3:0] PH_FLAGS   = 4'd3;
  localparam logic [3:0] PH_MID     = 4'd4;
  localparam logic [3:0] PH_ADDR    = 4'd5;
  localparam logic [3:0] PH_SIZE    = 4'd6;
  localparam logic [3:0] PH_PAYLOAD = 4'd7;
  localparam logic [3:0] PH_CRC     = 4'd8;

  logic [3:0]  phase_q, phase_d;
  logic [16:0] bcnt_q, bcnt_d;
  logic [15:0] size_q, size_d;
  logic [15:0] crc_run_q, crc_run_d;
  logic [15:0] crc_rcv_q, crc_rcv_d;
  logic        held_q, held_d;
  logic [7:0]  hdr_type_q, hdr_type_d;
  logic [7:0]  hdr_ver_q, hdr_ver_d;
  logic [5:0]  hdr_flags_q, hdr_flags_d;
  logic [7:0]  hdr_mid_q, hdr_mid_d;
  logic [7:0]  hdr_addr_q, hdr_addr_d;

  logic [7:0]  b;
  logic [3:0]  hdr_len;
  logic [16:0] pay_end;
  logic [16:0] crc_end;
  logic [2:0]  st;
  logic        pay;
  logic        err;
  logic [7:0]  rep_byte;
  logic [15:0] rep_size;

  assign b       = item_i.data_byte;
  assign hdr_len = hdr_flags_q[5] ? HdrLenAddr : HdrLenNoAddr;
  assign pay_end = 17'(hdr_len) + 17'(size_q);
  assign crc_end = pay_end + 17'd2;

  always_comb begin
    phase_d     = phase_q;
    bcnt_d      = bcnt_q;
    size_d      = size_q;
    crc_run_d   = crc_run_q;
    crc_rcv_d   = crc_rcv_q;
    held_d      = held_q;
    hdr_type_d  = hdr_type_q;
    hdr_ver_d   = hdr_ver_q;
    hdr_flags_d = hdr_flags_q;
    hdr_mid_d   = hdr_mid_q;
    hdr_addr_d  = hdr_addr_q;
    st          = ST_RECV;
    pay         = 1'b0;
    err         = 1'b0;
    rep_byte    = b;
    rep_size    = size_q;

    if (item_i.op == OP_RELEASE) begin
      // Release a held frame back to hunting; otherwise just report where we are.
      rep_byte = 8'h00;
      if (held_q) begin
        held_d    = 1'b0;
        phase_d   = PH_HUNT;
        size_d    = 16'h0000;
        crc_run_d = 16'h0000;
        crc_rcv_d = 16'h0000;
      end
      st       = (phase_d == PH_HUNT) ? ST_HUNT : ST_RECV;
      rep_size = size_d;
    end else if (held_q) begin
      st = ST_DROPPED;
    end else begin
      if (phase_q >= PH_TYPE && phase_q <= PH_PAYLOAD) begin
        crc_run_d = crc16_byte(crc_run_q, b);
      end
      case (phase_q)
        PH_TYPE: begin
          bcnt_d     = bcnt_q + 17'd1;
          hdr_type_d = b;
          phase_d    = PH_VER;
        end
        PH_VER: begin
          bcnt_d    = bcnt_q + 17'd1;
          hdr_ver_d = b;
          if (b <= cfg_i.max_version) begin
            phase_d = PH_FLAGS;
          end else begin
            st  = ST_VER_ERR;
            err = 1'b1;
          end
        end
        PH_FLAGS: begin
          bcnt_d      = bcnt_q + 17'd1;
          hdr_flags_d = b[5:0];
          phase_d     = PH_MID;
        end
        PH_MID: begin
          bcnt_d    = bcnt_q + 17'd1;
          hdr_mid_d = b;
          if (hdr_flags_q[5]) begin
            phase_d = PH_ADDR;
          end else begin
            hdr_addr_d = 8'h00;
            phase_d    = PH_SIZE;
          end
        end
        PH_ADDR: begin
          bcnt_d     = bcnt_q + 17'd1;
          hdr_addr_d = b;
          phase_d    = PH_SIZE;
        end
        PH_SIZE: begin
          bcnt_d = bcnt_q + 17'd1;
          size_d = {size_q[7:0], b};
          if (bcnt_d >= 17'(hdr_len)) begin
            if (size_d > cfg_i.max_payload) begin
              st  = ST_SIZE_ERR;
              err = 1'b1;
            end else begin
              phase_d = (size_d == 16'h0000) ? PH_CRC : PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          bcnt_d = bcnt_q + 17'd1;
          pay    = 1'b1;
          if (bcnt_d >= pay_end) begin
            phase_d = PH_CRC;
          end
        end
        PH_CRC: begin
          bcnt_d    = bcnt_q + 17'd1;
          crc_rcv_d = {crc_rcv_q[7:0], b};
          if (bcnt_d >= crc_end) begin
            if (crc_rcv_d == crc_run_q) begin
              held_d = 1'b1;
              st     = ST_DONE;
            end else begin
              st  = ST_CRC_ERR;
              err = 1'b1;
            end
          end
        end
        default: begin
          // Hunting, and any phase code that cannot be reached.
          if (b == cfg_i.head_byte) begin
            crc_run_d = 16'h0000;
            crc_rcv_d = 16'h0000;
            size_d    = 16'h0000;
            bcnt_d    = 17'd1;
            phase_d   = PH_TYPE;
          end else begin
            phase_d = PH_HUNT;
            st      = ST_HUNT;
          end
        end
      endcase
      // Report the length before an error wipes it.
      rep_size = size_d;
      if (err) begin
        phase_d   = PH_HUNT;
        size_d    = 16'h0000;
        crc_run_d = 16'h0000;
        crc_rcv_d = 16'h0000;
      end
    end

    res_o.status        = st;
    res_o.is_payload    = pay;
    res_o.out_byte      = rep_byte;
    res_o.frame_type    = hdr_type_d;
    res_o.frame_version = hdr_ver_d;
    res_o.frame_class   = hdr_flags_d[3:0];
    res_o.data_bit      = hdr_flags_d[4];
    res_o.has_addr      = hdr_flags_d[5];
    res_o.msg_id        = hdr_mid_d;
    res_o.dev_addr      = hdr_addr_d;
    res_o.payload_size  = rep_size;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HUNT;
      bcnt_q      <= '0;
      size_q      <= '0;
      crc_run_q   <= '0;
      crc_rcv_q   <= '0;
      held_q      <= 1'b0;
      hdr_type_q  <= '0;
      hdr_ver_q   <= '0;
      hdr_flags_q <= '0;
      hdr_mid_q   <= '0;
      hdr_addr_q  <= '0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      bcnt_q      <= bcnt_d;
      size_q      <= size_d;
      crc_run_q   <= crc_run_d;
      crc_rcv_q   <= crc_rcv_d;
      held_q      <= held_d;
      hdr_type_q  <= hdr_type_d;
      hdr_ver_q   <= hdr_ver_d;
      hdr_flags_q <= hdr_flags_d;
      hdr_mid_q   <= hdr_mid_d;
      hdr_addr_q  <= hdr_addr_d;
    end
  end

  `CFP_ASSERT_NOW(a_held_in_crc, clk_i, rst_ni, held_q, phase_q == PH_CRC)
  `CFP_ASSERT_NOW(a_hunt_clean, clk_i, rst_ni, phase_q == PH_HUNT,
                  size_q == 16'h0000 && crc_run_q == 16'h0000)
  `CFP_ASSERT_NOW(a_drop_while_held, clk_i, rst_ni, held_q && item_i.op == OP_BYTE,
                  res_o.status == ST_DROPPED && !res_o.is_payload)
  `CFP_ASSERT_NEXT(a_release_frees, clk_i, rst_ni,
                   step_i && held_q && item_i.op == OP_RELEASE,
                   !held_q && phase_q == PH_HUNT)

endmodule

/* rtl/core/crc_checked_frame_parser.sv */
// Byte-serial frame parser with CRC16/XMODEM check (poly 0x1021, init 0).
//   Input channel (in_valid_i / in_stall_o / in_item_i): one transaction per
//   received byte (op = byte) or per release request (op = release).
//   Output channel (out_valid_o / out_stall_i / out_item_o): exactly one result
//   transaction per input transaction, in order: status, payload flag, echoed
//   byte and the captured header fields of the current frame.
//   Config channel (cfg_valid_i / cfg_ready_o): ready is always high; index 0
//   head byte, 1 max version, 2 max payload length; other indexes are ignored.
//   Write config only while no transaction is in flight.
//   An accepted item waits in the input register and is stepped into the result
//   register once it can load. Throughput: one item per cycle while the output
//   is not stalled, set by the single input register and result register around
//   the per-byte step (the 8-bit CRC update is one byte-wide combinational step).
//   A stalled output holds its result; the input register then fills and
//   in_stall_o rises, so at most one item waits behind the held result.
//   Reset: parser hunts for a head byte, all counters, CRCs and captured fields
//   clear, config returns to head 0x5A, max version 1, max payload 256.
//   After a good CRC the frame is held: further bytes report dropped until a
//   release transaction returns the parser to hunting.
// Depends on cfp_pkg, cfp_cfg_regs and cfp_parser.
module crc_checked_frame_parser import cfp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic      in_valid_q, in_valid_d;
  in_item_t  in_item_q;
  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q;
  logic      advance;
  logic      step;
  logic      in_take;
  cfg_t      cfg;
  out_item_t res;

  cfp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  cfp_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Result register can load when empty or being drained this cycle.
  assign advance = !out_valid_q || !out_stall_i;
  assign step    = in_valid_q && advance;
  // Hold off the sender only when the input register is full and cannot move.
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = advance ? in_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: load on their own handshake events, no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q <= in_item_i;
    end
    if (step) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

/* bench/crc_checked_frame_parser_tb.sv */
// Self-checking bench for crc_checked_frame_parser: byte and release traffic in,
// per-byte parse reports out, each compared with an in-bench parser model.
// Depends on cfp_pkg (ports, status and register codes) and the parser RTL.
module crc_checked_frame_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cfp_pkg::*;

  localparam int QuietLimit = 4000;

  typedef enum logic [3:0] {
    PhHunt, PhType, PhVer, PhFlags, PhMid, PhAddr, PhSize, PhPayload, PhCrc
  } parse_phase_e;

  typedef enum {FrGood, FrBadCrc, FrBadVer, FrBadLen} frame_kind_e;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  in_item_t            in_item_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_item_t           out_item_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  // Register copies as the parser should see them.
  logic [7:0]  cfg_head    = HeadByteRst;
  logic [7:0]  cfg_max_ver = MaxVerRst;
  logic [15:0] cfg_max_len = MaxPayloadRst;

  // Parser state mirror.
  parse_phase_e ph         = PhHunt;
  logic [16:0]  seen_cnt   = '0;
  logic [15:0]  len_acc    = '0;
  logic [15:0]  crc_acc    = '0;
  logic [15:0]  crc_got    = '0;
  logic         frame_held = 1'b0;
  logic [7:0]   cap_type   = '0;
  logic [7:0]   cap_ver    = '0;
  logic [5:0]   cap_flags  = '0;
  logic [7:0]   cap_mid    = '0;
  logic [7:0]   cap_addr   = '0;

  in_item_t  rx_bytes_q[$];      // bytes and releases waiting to be sent
  out_item_t byte_reports_q[$];  // predicted reports, oldest first

  int  queued_items = 0;
  int  rx_gap = 0;
  int  stall_left = 0;
  int  quiet_cycles = 0;
  int  mismatches = 0;
  int  reports_seen = 0;
  int  status_count[8];
  int  payload_bytes = 0;
  bit  rx_taken = 1'b0;
  bit  rx_gaps_on = 1'b1;
  bit  tx_stalls_on = 1'b1;

  crc_checked_frame_parser i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_item_i,
    .out_valid_o,
    .out_stall_i,
    .out_item_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // ---------------------------------------------------------------------------
  // Parser model
  // ---------------------------------------------------------------------------

  // CRC16/XMODEM, one input bit at a time, MSB first.
  function automatic logic [15:0] crc_xmodem_step(logic [15:0] crc, logic [7:0] b);
    logic fb;
    for (int k = 7; k >= 0; k--) begin
      fb  = crc[15] ^ b[k];
      crc = {crc[14:0], 1'b0} ^ (fb ? CrcPoly : 16'h0000);
    end
    return crc;
  endfunction

  // Build a report from the captured header as it stands now.
  function automatic out_item_t make_report(logic [2:0] st, logic pay, logic [7:0] b);
    out_item_t r;
    r.status        = st;
    r.is_payload    = pay;
    r.out_byte      = b;
    r.frame_type    = cap_type;
    r.frame_version = cap_ver;
    r.frame_class   = cap_flags[3:0];
    r.data_bit      = cap_flags[4];
    r.has_addr      = cap_flags[5];
    r.msg_id        = cap_mid;
    r.dev_addr      = cap_addr;
    r.payload_size  = len_acc;
    return r;
  endfunction

  // Drop the frame in progress; captured header bytes stay.
  function automatic void return_to_hunt();
    ph      = PhHunt;
    len_acc = '0;
    crc_acc = '0;
    crc_got = '0;
  endfunction

  // Advance the parser mirror by one transaction and return its report.
  function automatic out_item_t parse_step(in_item_t it);
    out_item_t  r;
    logic [2:0] st;
    logic       pay;
    logic [7:0] b;
    int         hdr_len;
    st  = ST_RECV;
    pay = 1'b0;
    b   = it.data_byte;
    if (it.op == OP_RELEASE) begin
      if (frame_held) begin
        frame_held = 1'b0;
        return_to_hunt();
      end
      return make_report((ph == PhHunt) ? ST_HUNT : ST_RECV, 1'b0, 8'h00);
    end
    // A held frame swallows bytes untouched.
    if (frame_held) return make_report(ST_DROPPED, 1'b0, b);

    if (ph >= PhType && ph <= PhPayload) crc_acc = crc_xmodem_step(crc_acc, b);
    hdr_len = cap_flags[5] ? int'(HdrLenAddr) : int'(HdrLenNoAddr);

    case (ph)
      PhType: begin
        seen_cnt++;
        cap_type = b;
        ph = PhVer;
      end
      PhVer: begin
        seen_cnt++;
        cap_ver = b;
        if (b <= cfg_max_ver) begin
          ph = PhFlags;
        end else begin
          r = make_report(ST_VER_ERR, 1'b0, b);
          return_to_hunt();
          return r;
        end
      end
      PhFlags: begin
        seen_cnt++;
        cap_flags = b[5:0];
        ph = PhMid;
      end
      PhMid: begin
        seen_cnt++;
        cap_mid = b;
        if (cap_flags[5]) begin
          ph = PhAddr;
        end else begin
          cap_addr = 8'h00;
          ph = PhSize;
        end
      end
      PhAddr: begin
        seen_cnt++;
        cap_addr = b;
        ph = PhSize;
      end
      PhSize: begin
        seen_cnt++;
        len_acc = {len_acc[7:0], b};
        if (seen_cnt >= hdr_len) begin
          if (len_acc > cfg_max_len) begin
            r = make_report(ST_SIZE_ERR, 1'b0, b);
            return_to_hunt();
            return r;
          end
          // An empty payload skips straight to the CRC bytes.
          ph = (len_acc == 16'h0000) ? PhCrc : PhPayload;
        end
      end
      PhPayload: begin
        seen_cnt++;
        pay = 1'b1;
        if (seen_cnt >= hdr_len + len_acc) ph = PhCrc;
      end
      PhCrc: begin
        seen_cnt++;
        crc_got = {crc_got[7:0], b};
        if (seen_cnt >= hdr_len + len_acc + 2) begin
          if (crc_got == crc_acc) begin
            frame_held = 1'b1;
            st = ST_DONE;
          end else begin
            r = make_report(ST_CRC_ERR, 1'b0, b);
            return_to_hunt();
            return r;
          end
        end
      end
      default: begin
        // Hunting: only the head byte opens a frame; it is not CRC covered.
        if (b == cfg_head) begin
          crc_acc  = '0;
          crc_got  = '0;
          len_acc  = '0;
          seen_cnt = 17'd1;
          ph = PhType;
        end else begin
          ph = PhHunt;
          st = ST_HUNT;
        end
      end
    endcase
    return make_report(st, pay, b);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Mostly short payloads; now and then a longer one within the limit.
  function automatic int pick_len();
    int cap;
    cap = (cfg_max_len < 8) ? int'(cfg_max_len) : 8;
    if ($urandom_range(0, 19) == 0) cap = (cfg_max_len < 300) ? int'(cfg_max_len) : 300;
    return $urandom_range(0, cap);
  endfunction

  task automatic push_byte(logic [7:0] b);
    rx_bytes_q.push_back({OP_BYTE, b});
    queued_items++;
  endtask

  task automatic push_release();
    logic [7:0] junk;
    junk = 8'($urandom_range(0, 255));
    rx_bytes_q.push_back({OP_RELEASE, junk});
    queued_items++;
  endtask

  // Queue one frame. Version and length rejects stop right after the offending
  // byte so that the parser is left hunting for the next head.
  task automatic queue_frame(frame_kind_e kind, logic [7:0] ftype, logic [7:0] ver,
                             logic [7:0] flags, logic [7:0] mid, logic [7:0] addr,
                             int len);
    logic [7:0]  body[$];
    logic [15:0] crc;
    body.push_back(ftype);
    body.push_back(ver);
    if (kind != FrBadVer) begin
      body.push_back(flags);
      body.push_back(mid);
      if (flags[5]) body.push_back(addr);
      body.push_back(len[15:8]);
      body.push_back(len[7:0]);
      if (kind != FrBadLen) begin
        for (int i = 0; i < len; i++) body.push_back(8'($urandom_range(0, 255)));
      end
    end
    crc = 16'h0000;
    push_byte(cfg_head);
    foreach (body[i]) begin
      push_byte(body[i]);
      crc = crc_xmodem_step(crc, body[i]);
    end
    if (kind == FrGood || kind == FrBadCrc) begin
      if (kind == FrBadCrc) crc ^= 16'($urandom_range(1, 65535));
      push_byte(crc[15:8]);
      push_byte(crc[7:0]);
    end
  endtask

  // Mostly well-formed frames with random content, then rejects and noise.
  task automatic queue_random_traffic(int n_items);
    int goal;
    int pick;
    goal = queued_items + n_items;
    while (queued_items < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 68 || (pick >= 78 && pick < 85 && cfg_max_ver == 8'hFF)
          || (pick >= 85 && pick < 91 && cfg_max_len == 16'hFFFF)) begin
        queue_frame(FrGood, 8'($urandom), 8'($urandom_range(0, cfg_max_ver)), 8'($urandom),
                    8'($urandom), 8'($urandom), pick_len());
        // Sometimes let a few bytes hit the held frame before releasing it.
        if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3)) push_byte(8'($urandom));
        push_release();
      end else if (pick < 78) begin
        queue_frame(FrBadCrc, 8'($urandom), 8'($urandom_range(0, cfg_max_ver)), 8'($urandom),
                    8'($urandom), 8'($urandom), pick_len());
      end else if (pick < 85) begin
        queue_frame(FrBadVer, 8'($urandom), 8'($urandom_range(cfg_max_ver + 1, 255)),
                    8'h00, 8'h00, 8'h00, 0);
      end else if (pick < 91) begin
        queue_frame(FrBadLen, 8'($urandom), 8'($urandom_range(0, cfg_max_ver)), 8'($urandom),
                    8'($urandom), 8'($urandom),
                    int'($urandom_range(cfg_max_len + 1, 65535)));
      end else if (pick < 96) begin
        repeat ($urandom_range(1, 4)) push_byte(8'($urandom));
      end else begin
        push_release();
      end
    end
  endtask

  // Hold off until every queued transaction has been sent and reported,
  // then let the pipeline settle.
  task automatic drain_parser();
    do begin
      @(negedge clk_i);
      #1;
    end while (rx_bytes_q.size() != 0 || in_valid_i || byte_reports_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    // The write lands at this edge; mirror it.
    case (idx)
      CfgHeadByte: cfg_head    = val[7:0];
      CfgMaxVer:   cfg_max_ver = val[7:0];
      CfgMaxPayld: cfg_max_len = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_config(logic [7:0] head, logic [7:0] max_ver, logic [15:0] max_len);
    write_reg(CfgHeadByte, {8'h00, head});
    write_reg(CfgMaxVer, {8'h00, max_ver});
    write_reg(CfgMaxPayld, max_len);
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic cmp_field(string name, logic [15:0] want_v, logic [15:0] got_v);
    if (got_v !== want_v) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want_v, got_v);
    end
  endtask

  task automatic check_report(out_item_t got);
    out_item_t want;
    if (byte_reports_q.size() == 0) begin
      mismatches++;
      $display("%0t: report with nothing outstanding: expected none, actual %h", $time, got);
    end else begin
      want = byte_reports_q.pop_front();
      cmp_field("status", want.status, got.status);
      cmp_field("is_payload", want.is_payload, got.is_payload);
      cmp_field("out_byte", want.out_byte, got.out_byte);
      cmp_field("frame_type", want.frame_type, got.frame_type);
      cmp_field("frame_version", want.frame_version, got.frame_version);
      cmp_field("frame_class", want.frame_class, got.frame_class);
      cmp_field("data_bit", want.data_bit, got.data_bit);
      cmp_field("has_addr", want.has_addr, got.has_addr);
      cmp_field("msg_id", want.msg_id, got.msg_id);
      cmp_field("dev_addr", want.dev_addr, got.dev_addr);
      cmp_field("payload_size", want.payload_size, got.payload_size);
    end
    if (!$isunknown(got.status)) status_count[got.status]++;
    if (got.is_payload === 1'b1) payload_bytes++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: present the next queued transaction at the falling edge, hold it
  // while stalled, and insert random gaps between transactions.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || rx_taken) begin
      if (rx_gap > 0) begin
        in_valid_i <= 1'b0;
        rx_gap--;
      end else if (rx_bytes_q.size() != 0) begin
        in_valid_i <= 1'b1;
        in_item_i  <= rx_bytes_q.pop_front();
        rx_gap = rx_gaps_on ? pick_gap() : 0;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Output back-pressure: random stall bursts, mostly one cycle, some long.
  always @(negedge clk_i) begin
    if (!rst_ni || !tx_stalls_on) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
      if ($urandom_range(0, 99) < 25) stall_left = pick_gap() + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: at each rising edge check an accepted report against the oldest
  // prediction, then run the model on an accepted input transaction.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    rx_taken = 1'b0;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        check_report(out_item_o);
        reports_seen++;
      end
      if (in_valid_i && !in_stall_o) begin
        rx_taken = 1'b1;
        byte_reports_q.push_back(parse_step(in_item_i));
      end
    end
  end

  // Watchdog: end the run when no transaction of any kind moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)
        || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("%0t: no transaction for %0d cycles, %0d reports outstanding",
               $time, QuietLimit, byte_reports_q.size());
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    foreach (status_count[i]) status_count[i] = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part under reset register values.
    push_release();                 // release with nothing held
    push_byte(8'hFF);               // noise while hunting
    // Zero-length frame with address, every flag bit set, then held.
    queue_frame(FrGood, 8'hFF, 8'h01, 8'hFF, 8'h00, 8'hFF, 0);
    push_byte(cfg_head);            // dropped while held
    push_release();
    // Version reject, with a release arriving inside the frame.
    push_byte(cfg_head);
    push_byte(8'h00);
    push_release();
    push_byte(8'h02);
    // Length one above the limit.
    queue_frame(FrBadLen, 8'h01, 8'h00, 8'h00, 8'h7F, 8'h00, 257);
    drain_parser();

    // Low extremes: head 0, version 0 only, empty payloads only; no idling.
    rx_gaps_on   = 1'b0;
    tx_stalls_on = 1'b0;
    set_config(8'h00, 8'h00, 16'h0000);
    queue_random_traffic(370);
    drain_parser();

    // High extremes: head 0xFF, every version and length accepted.
    rx_gaps_on   = 1'b1;
    tx_stalls_on = 1'b1;
    set_config(8'hFF, 8'hFF, 16'hFFFF);
    queue_random_traffic(370);
    drain_parser();

    // Random setting with a tight length limit; sender idles, receiver never stalls.
    tx_stalls_on = 1'b0;
    set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 254)),
               16'($urandom_range(1, 64)));
    queue_random_traffic(370);
    drain_parser();

    // Back to the reset values with both sides idling.
    tx_stalls_on = 1'b1;
    set_config(HeadByteRst, MaxVerRst, MaxPayloadRst);
    queue_random_traffic(370);
    drain_parser();

    $display("Sent %0d transactions over five register settings; %0d reports checked.",
             queued_items, reports_seen);
    $display("Outcomes: %0d good, %0d ver, %0d len, %0d crc errs, %0d drops, %0d payload",
             status_count[ST_DONE], status_count[ST_VER_ERR], status_count[ST_SIZE_ERR],
             status_count[ST_CRC_ERR], status_count[ST_DROPPED], payload_bytes);
    if (mismatches == 0 && byte_reports_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/cfp_pkg.sv
rtl/core/cfp_cfg_regs.sv
rtl/core/cfp_parser.sv
rtl/core/crc_checked_frame_parser.sv
bench/crc_checked_frame_parser_tb.sv
